@@ src/exponential_pitch_glide_unit_macros.svh @@
// Assertion macros for the exponential pitch glide unit.
// Expects clk and rst_n in the scope of the module that includes this file.
`ifndef EXPONENTIAL_PITCH_GLIDE_UNIT_MACROS_SVH
`define EXPONENTIAL_PITCH_GLIDE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define EPG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define EPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/epg_pkg.sv @@
// Shared types and constants for the exponential pitch glide unit.
// No dependencies.
package epg_pkg;

    localparam int FREQ_W         = 32;
    localparam int FREQ_FRAC_BITS = 16;
    localparam int DIGIT_W        = 4;
    localparam int GLIDE_COEFF_W  = 25;
    localparam int SNAP_RATIO_W   = 24;
    localparam int APB_ADDR_W     = 4;
    localparam int APB_DATA_W     = 32;

    localparam logic [FREQ_W-1:0] RESET_FREQ = FREQ_W'(64'd440 << FREQ_FRAC_BITS);

    localparam logic [GLIDE_COEFF_W-1:0] COEFF_RESET = GLIDE_COEFF_W'(25'd16777216);
    localparam logic [SNAP_RATIO_W-1:0]  RATIO_RESET = SNAP_RATIO_W'(24'd168);

    // register word index (paddr[3:2])
    typedef enum logic [1:0] {
        REG_GLIDE_ENABLE = 2'd0,
        REG_LEGATO_ONLY  = 2'd1,
        REG_GLIDE_COEFF  = 2'd2,
        REG_SNAP_RATIO   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_SET_TARGET = 2'd1,
        OP_SNAP       = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_STEP,
        ST_UPDATE,
        ST_MUL_SNAP,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic start_mul;
        logic mul_run;
        logic update;
        logic check;
        logic emit;
    } ctrl_t;

endpackage

@@ src/exponential_pitch_glide_unit.sv @@
// Tick while gliding: IDLE accepts, MUL_STEP forms the step, UPDATE moves the current
// frequency, MUL_SNAP and CHECK apply the snap ratio, DONE emits the word once output is free.
// Other words go from IDLE to DONE. No new word is accepted until the FSM is back in IDLE.
// One shared 4-bit-digit serial multiplier is run twice per gliding tick.
// Async active-low reset: 440 Hz current/target, glide off, registers to defaults.
// Uses epg_pkg and exponential_pitch_glide_unit_macros.svh.
`include "exponential_pitch_glide_unit_macros.svh"

module exponential_pitch_glide_unit #(
    parameter int COEFF_FRAC_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      opcode,
    input  logic [epg_pkg::FREQ_W-1:0]      freq_in,
    input  logic                            is_legato,
    // output channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [epg_pkg::FREQ_W-1:0]      freq_out,
    output logic                            gliding,
    // config port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [epg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [epg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [epg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int FW    = epg_pkg::FREQ_W;
    localparam int DW    = epg_pkg::DIGIT_W;
    localparam int CFB   = COEFF_FRAC_BITS;
    localparam int MB    = (CFB + 1 > epg_pkg::SNAP_RATIO_W) ? CFB + 1 : epg_pkg::SNAP_RATIO_W;
    localparam int NDIG  = (MB + DW - 1) / DW;
    localparam int MBR   = NDIG * DW;
    localparam int PW    = FW + MBR;
    localparam int CNT_W = $clog2(NDIG);
    localparam int CEW   = (CFB + 2 > epg_pkg::GLIDE_COEFF_W) ? CFB + 2 : epg_pkg::GLIDE_COEFF_W;

    localparam logic [CEW-1:0]   COEFF_UNITY = {{(CEW-1){1'b0}}, 1'b1} << CFB;
    localparam logic [CNT_W-1:0] CNT_LAST    = CNT_W'(NDIG - 1);

    // config registers
    logic                                glide_enable_reg, glide_enable_next;
    logic                                legato_only_reg,  legato_only_next;
    logic [epg_pkg::GLIDE_COEFF_W-1:0]   glide_coeff_reg,  glide_coeff_next;
    logic [epg_pkg::SNAP_RATIO_W-1:0]    snap_ratio_reg,   snap_ratio_next;

    // glide state
    logic [FW-1:0]        current_reg, current_next;
    logic [FW-1:0]        target_reg,  target_next;
    logic                 active_reg,  active_next;

    // serial multiplier and tick scratch
    epg_pkg::state_t      state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg,   cnt_next;
    logic [FW-1:0]        mul_a_reg, mul_a_next;
    logic [MBR-1:0]       mul_b_reg, mul_b_next;
    logic [PW-1:0]        prod_reg,  prod_next;
    logic                 dir_reg,   dir_next;
    logic [FW-1:0]        diff_reg,  diff_next;
    logic [FW-1:0]        dist_reg,  dist_next;

    // output word
    logic                 out_valid_reg, out_valid_next;
    logic [FW-1:0]        freq_out_reg,  freq_out_next;
    logic                 gliding_reg,   gliding_next;

    epg_pkg::ctrl_t       ctrl;

    logic                 cfg_wr;
    logic                 accept;
    logic                 out_free;
    logic                 mul_last;
    logic                 dir_up;
    logic [FW-1:0]        diff_now;
    logic [CEW-1:0]       coeff_ext;
    logic [CEW-1:0]       coeff_sat;
    logic [FW+DW-1:0]     mul_sum;
    logic [FW-1:0]        step;
    logic [PW-1:0]        snap_lhs;
    logic                 snap_hit;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign accept   = in_valid && ctrl.in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign mul_last = (cnt_reg == CNT_LAST);

    assign in_ready  = ctrl.in_ready;
    assign out_valid = out_valid_reg;
    assign freq_out  = freq_out_reg;
    assign gliding   = gliding_reg;

    // datapath helpers
    assign dir_up    = (target_reg >= current_reg);
    assign diff_now  = dir_up ? (target_reg - current_reg) : (current_reg - target_reg);
    assign coeff_ext = CEW'(glide_coeff_reg);
    assign coeff_sat = (coeff_ext > COEFF_UNITY) ? COEFF_UNITY : coeff_ext;

    // one radix-16 digit per cycle; the high part stays below 16*a, so FW+DW bits hold it
    assign mul_sum = (FW+DW)'(prod_reg[PW-1:MBR])
                   + (FW+DW)'(mul_a_reg) * (FW+DW)'(mul_b_reg[DW-1:0]);

    assign step     = prod_reg[CFB +: FW];
    assign snap_lhs = PW'({dist_reg, {CFB{1'b0}}});
    assign snap_hit = (dist_reg == '0) || (snap_lhs < prod_reg);

    always_comb
    begin
        case (paddr[3:2])
            epg_pkg::REG_GLIDE_ENABLE: prdata = epg_pkg::APB_DATA_W'(glide_enable_reg);
            epg_pkg::REG_LEGATO_ONLY:  prdata = epg_pkg::APB_DATA_W'(legato_only_reg);
            epg_pkg::REG_GLIDE_COEFF:  prdata = epg_pkg::APB_DATA_W'(glide_coeff_reg);
            epg_pkg::REG_SNAP_RATIO:   prdata = epg_pkg::APB_DATA_W'(snap_ratio_reg);
            default:                   prdata = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            epg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == epg_pkg::OP_TICK && active_reg)
                        state_next = epg_pkg::ST_MUL_STEP;
                    else
                        state_next = epg_pkg::ST_DONE;
                end
            end
            epg_pkg::ST_MUL_STEP:
            begin
                if (mul_last)
                    state_next = epg_pkg::ST_UPDATE;
            end
            epg_pkg::ST_UPDATE:
                state_next = epg_pkg::ST_MUL_SNAP;
            epg_pkg::ST_MUL_SNAP:
            begin
                if (mul_last)
                    state_next = epg_pkg::ST_CHECK;
            end
            epg_pkg::ST_CHECK:
                state_next = epg_pkg::ST_DONE;
            epg_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = epg_pkg::ST_IDLE;
            end
            default:
                state_next = epg_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            epg_pkg::ST_IDLE:
            begin
                ctrl.in_ready  = 1'b1;
                ctrl.start_mul = in_valid && (opcode == epg_pkg::OP_TICK) && active_reg;
            end
            epg_pkg::ST_MUL_STEP: ctrl.mul_run = 1'b1;
            epg_pkg::ST_UPDATE:   ctrl.update  = 1'b1;
            epg_pkg::ST_MUL_SNAP: ctrl.mul_run = 1'b1;
            epg_pkg::ST_CHECK:    ctrl.check   = 1'b1;
            epg_pkg::ST_DONE:     ctrl.emit    = out_free;
            default:              ctrl         = '0;
        endcase
    end

    // datapath and register updates
    always_comb
    begin
        glide_enable_next = glide_enable_reg;
        legato_only_next  = legato_only_reg;
        glide_coeff_next  = glide_coeff_reg;
        snap_ratio_next   = snap_ratio_reg;
        current_next      = current_reg;
        target_next       = target_reg;
        active_next       = active_reg;
        cnt_next          = cnt_reg;
        mul_a_next        = mul_a_reg;
        mul_b_next        = mul_b_reg;
        prod_next         = prod_reg;
        dir_next          = dir_reg;
        diff_next         = diff_reg;
        dist_next         = dist_reg;
        out_valid_next    = out_valid_reg;
        freq_out_next     = freq_out_reg;
        gliding_next      = gliding_reg;

        if (cfg_wr)
        begin
            case (paddr[3:2])
                epg_pkg::REG_GLIDE_ENABLE: glide_enable_next = pwdata[0];
                epg_pkg::REG_LEGATO_ONLY:  legato_only_next  = pwdata[0];
                epg_pkg::REG_GLIDE_COEFF:
                    glide_coeff_next = pwdata[epg_pkg::GLIDE_COEFF_W-1:0];
                epg_pkg::REG_SNAP_RATIO:
                    snap_ratio_next  = pwdata[epg_pkg::SNAP_RATIO_W-1:0];
                default: ;
            endcase
        end

        if (accept)
        begin
            case (opcode)
                epg_pkg::OP_TICK:
                begin
                    // tick while idle changes nothing
                    if (ctrl.start_mul)
                    begin
                        mul_a_next = diff_now;
                        mul_b_next = MBR'(coeff_sat);
                        prod_next  = '0;
                        cnt_next   = '0;
                        dir_next   = dir_up;
                        diff_next  = diff_now;
                    end
                end
                epg_pkg::OP_SET_TARGET:
                begin
                    target_next = freq_in;
                    if (!glide_enable_reg || (legato_only_reg && !is_legato))
                    begin
                        current_next = freq_in;
                        active_next  = 1'b0;
                    end
                    else
                        active_next  = 1'b1;
                end
                epg_pkg::OP_SNAP:
                begin
                    current_next = freq_in;
                    target_next  = freq_in;
                    active_next  = 1'b0;
                end
                default: ;
            endcase
        end

        if (ctrl.mul_run)
        begin
            prod_next  = {mul_sum, prod_reg[MBR-1:DW]};
            mul_b_next = mul_b_reg >> DW;
            cnt_next   = cnt_reg + CNT_W'(1);
        end

        if (ctrl.update)
        begin
            // truncated step never exceeds the distance, so no overshoot
            current_next = dir_reg ? (current_reg + step) : (current_reg - step);
            dist_next    = diff_reg - step;
            mul_a_next   = target_reg;
            mul_b_next   = MBR'(snap_ratio_reg);
            prod_next    = '0;
            cnt_next     = '0;
        end

        if (ctrl.check && snap_hit)
        begin
            current_next = target_reg;
            active_next  = 1'b0;
        end

        if (ctrl.emit)
        begin
            out_valid_next = 1'b1;
            freq_out_next  = current_reg;
            gliding_next   = active_reg;
        end
        else if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= epg_pkg::ST_IDLE;
            cnt_reg          <= '0;
            glide_enable_reg <= 1'b0;
            legato_only_reg  <= 1'b0;
            glide_coeff_reg  <= epg_pkg::COEFF_RESET;
            snap_ratio_reg   <= epg_pkg::RATIO_RESET;
            current_reg      <= epg_pkg::RESET_FREQ;
            target_reg       <= epg_pkg::RESET_FREQ;
            active_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            glide_enable_reg <= glide_enable_next;
            legato_only_reg  <= legato_only_next;
            glide_coeff_reg  <= glide_coeff_next;
            snap_ratio_reg   <= snap_ratio_next;
            current_reg      <= current_next;
            target_reg       <= target_next;
            active_reg       <= active_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        prod_reg     <= prod_next;
        dir_reg      <= dir_next;
        diff_reg     <= diff_next;
        dist_reg     <= dist_next;
        freq_out_reg <= freq_out_next;
        gliding_reg  <= gliding_next;
    end

    `EPG_ASSERT_NOW(a_rest_on_target, !active_reg, current_reg == target_reg, "idle but off target")
    `EPG_ASSERT_NEXT(a_one_word_in_flight, accept, !in_ready, "second word taken while busy")
    `EPG_ASSERT_NOW(a_step_in_range, state_reg == epg_pkg::ST_UPDATE, step <= diff_reg, "overshoot")

endmodule
